>>> rtl/kpc_pkg.sv
// kpc_pkg: shared types and constants for the key press classifier
`default_nettype none

package kpc_pkg;

   // widths fixed by the item and register fields
   localparam int LEVEL_BITS  = 6;
   localparam int CODE_BITS   = 4;
   localparam int NUMBER_BITS = 4;
   localparam int ACTION_BITS = 4;
   localparam int THR_BITS    = 8;
   localparam int CSR_IDX_BITS = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_TICKS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHORT_MIN  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ENC_MODE   = 2'd2;

   // register reset values
   localparam logic [THR_BITS-1:0] LONG_TICKS_RESET = 8'd80;
   localparam logic [THR_BITS-1:0] SHORT_MIN_RESET  = 8'd2;

   // largest event code a set may write
   localparam logic [ACTION_BITS-1:0] ACTION_MAX = 4'd3;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_DOWN  = 2'd1,
      EV_SHORT = 2'd2,
      EV_LONG  = 2'd3
   } ev_type;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_READ = 2'd1,
      REQ_SET  = 2'd2
   } req_kind_type;

   // one accepted item as broadcast to the lanes
   typedef struct packed {
      logic                   fire;
      req_kind_type           kind;
      logic [LEVEL_BITS-1:0]  levels;
      logic [CODE_BITS-1:0]   code;
      logic [NUMBER_BITS-1:0] number;
      logic [ACTION_BITS-1:0] action;
   } cmd_type;

   // configuration seen by every lane
   typedef struct packed {
      logic [THR_BITS-1:0] long_ticks;
      logic [THR_BITS-1:0] short_min;
      logic                encoded;
   } cfg_type;

   // merged result of one item
   typedef struct packed {
      ev_type event_code;
      logic   set_failed;
      logic   wake_request;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/key_press_classifier.sv
// key_press_classifier: short/long press classifier for a row of keys
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | type, key_levels, key_code, key_number, set_action
//   rsp     | out       | rsp_valid/rsp_ready   | event_code, set_failed, wake_request
//   csr     | in        | csr_write_enable      | csr_index, csr_write_data
//
// Each key has its own lane. One item per cycle unless the output stalls; its result
// passes the merge stage into one output register and shows in the cycle after acceptance.
// req_ready is high whenever the output register is empty or being emptied.
// Synchronous reset restores the register defaults and clears all events, counts and locks.
// A stalled result holds in the output register and blocks new items until it is taken.
`default_nettype none

module key_press_classifier
   import kpc_pkg::*;
#(
   parameter int NUM_KEYS   = 6,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_type,
   input  wire logic [LEVEL_BITS-1:0]   req_key_levels,
   input  wire logic [CODE_BITS-1:0]    req_key_code,
   input  wire logic [NUMBER_BITS-1:0]  req_key_number,
   input  wire logic [ACTION_BITS-1:0]  req_set_action,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_event_code,
   output logic                         rsp_set_failed,
   output logic                         rsp_wake_request,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [THR_BITS-1:0]     csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   rsp_type merged;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    req_fire;

   ev_type  lane_event [NUM_KEYS];
   ev_type  lane_next  [NUM_KEYS];

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LONG_TICKS: cfg_in.long_ticks = csr_write_data;
            CSR_SHORT_MIN:  cfg_in.short_min  = csr_write_data;
            CSR_ENC_MODE:   cfg_in.encoded    = csr_write_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_ticks <= LONG_TICKS_RESET;
         cfg_ff.short_min  <= SHORT_MIN_RESET;
         cfg_ff.encoded    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake and item broadcast
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   assign cmd.fire   = req_fire;
   assign cmd.kind   = req_kind_type'(req_type);
   assign cmd.levels = req_key_levels;
   assign cmd.code   = req_key_code;
   assign cmd.number = req_key_number;
   assign cmd.action = req_set_action;

   // one lane per key
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      kpc_lane #(
         .IDX        (k),
         .COUNT_BITS (COUNT_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cfg        (cfg_ff),
         .event_cur  (lane_event[k]),
         .event_next (lane_next[k])
      );
   end

   kpc_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .cmd        (cmd),
      .lane_event (lane_event),
      .lane_next  (lane_next),
      .rsp        (merged)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_code   = rsp_ff.event_code;
   assign rsp_set_failed   = rsp_ff.set_failed;
   assign rsp_wake_request = rsp_ff.wake_request;

   // every accepted item yields a result in the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   // an empty output register never blocks the input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   // a failed set never wakes
   a_fail_no_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_failed |-> !rsp_wake_request)
      else $error("failed set also requested wake");

   // a result with a nonzero event code (a read) carries no set or wake flags
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code != EV_NONE |-> !rsp_set_failed && !rsp_wake_request)
      else $error("read result mixed with set or wake flags");

   // a held result stays put while stalled
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ff))
      else $error("stalled result changed");

endmodule

`default_nettype wire

>>> rtl/kpc_lane.sv
// kpc_lane: event, hold counter and lock of one key
`default_nettype none

module kpc_lane
   import kpc_pkg::*;
#(
   parameter int IDX        = 0,
   parameter int COUNT_BITS = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire cfg_type cfg,
   output ev_type       event_cur,
   output ev_type       event_next
);

   localparam int CMP_BITS = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [NUMBER_BITS-1:0] MY_NUMBER = NUMBER_BITS'(IDX + 1);
   localparam logic [CODE_BITS-1:0]   MY_CODE   = CODE_BITS'(IDX);

   ev_type                event_ff, event_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  lock_ff, lock_in;

   logic                  pin_pressed;
   logic                  pressed;
   logic                  selected;
   logic [COUNT_BITS-1:0] count_inc;
   logic [CMP_BITS-1:0]   count_inc_wide, count_wide;
   logic [CMP_BITS-1:0]   long_wide, short_wide;

   // per-pin line; keys beyond the level field read as released
   generate
      if (IDX < LEVEL_BITS) begin : g_pin
         assign pin_pressed = ~cmd.levels[IDX];
      end else begin : g_no_pin
         assign pin_pressed = 1'b0;
      end
   endgenerate

   assign pressed  = cfg.encoded ? (cmd.code == MY_CODE) : pin_pressed;
   assign selected = (cmd.number == MY_NUMBER);

   // saturating increment and common-width compares
   assign count_inc      = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign count_inc_wide = CMP_BITS'(count_inc);
   assign count_wide     = CMP_BITS'(count_ff);
   assign long_wide      = CMP_BITS'(cfg.long_ticks);
   assign short_wide     = CMP_BITS'(cfg.short_min);

   // next state of this key
   always_comb begin
      event_in = event_ff;
      count_in = count_ff;
      lock_in  = lock_ff;
      if (cmd.fire) begin
         case (cmd.kind)
            REQ_TICK: begin
               if (pressed) begin
                  if (!lock_ff) begin
                     event_in = EV_DOWN;
                     count_in = count_inc;
                     if (count_inc_wide >= long_wide) begin
                        event_in = EV_LONG;
                        lock_in  = 1'b1;
                     end
                  end
               end else begin
                  if (count_wide >= short_wide && count_wide < long_wide) begin
                     event_in = EV_SHORT;
                  end
                  count_in = '0;
                  lock_in  = 1'b0;
               end
            end
            REQ_READ: begin
               if (selected) begin
                  event_in = EV_NONE;
               end
            end
            REQ_SET: begin
               if (selected && cmd.action <= ACTION_MAX && event_ff == EV_NONE) begin
                  event_in = ev_type'(cmd.action[1:0]);
               end
            end
            default: begin
               event_in = event_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_ff <= EV_NONE;
         count_ff <= '0;
         lock_ff  <= 1'b0;
      end else begin
         event_ff <= event_in;
         count_ff <= count_in;
         lock_ff  <= lock_in;
      end
   end

   assign event_cur  = event_ff;
   assign event_next = event_in;

endmodule

`default_nettype wire

>>> rtl/kpc_merge.sv
// kpc_merge: combines the lane events into one result item
`default_nettype none

module kpc_merge
   import kpc_pkg::*;
#(
   parameter int NUM_KEYS = 6
) (
   input  wire cmd_type cmd,
   input  wire ev_type  lane_event [NUM_KEYS],
   input  wire ev_type  lane_next  [NUM_KEYS],
   output rsp_type      rsp
);

   ev_type sel_event;
   logic   sel_hit;
   logic   any_pending;

   // pick the addressed lane and look for any pending event
   always_comb begin
      sel_event   = EV_NONE;
      sel_hit     = 1'b0;
      any_pending = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (cmd.number == NUMBER_BITS'(k + 1)) begin
            sel_event = lane_event[k];
            sel_hit   = 1'b1;
         end
         if (lane_next[k] != EV_NONE) begin
            any_pending = 1'b1;
         end
      end
   end

   // result fields by request kind
   always_comb begin
      rsp.event_code   = EV_NONE;
      rsp.set_failed   = 1'b0;
      rsp.wake_request = 1'b0;
      case (cmd.kind)
         REQ_TICK: begin
            rsp.wake_request = any_pending;
         end
         REQ_READ: begin
            rsp.event_code = sel_event;
         end
         REQ_SET: begin
            if (!sel_hit || cmd.action > ACTION_MAX || sel_event != EV_NONE) begin
               rsp.set_failed = 1'b1;
            end else begin
               rsp.wake_request = 1'b1;
            end
         end
         default: begin
            rsp.event_code = EV_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire
